[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bavg_pkg.sv]
`default_nettype none

package bavg_pkg;

    localparam int PIX_W        = 8;
    localparam int SUM_W        = 16;
    localparam int OUT_W        = 10;
    localparam int CFG_W        = 11;
    localparam int BS_W         = 5;
    localparam int IDX_W        = 2;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int Y_W          = $clog2(HEIGHT_LIMIT);
    localparam int DIV_CNT_W    = $clog2(SUM_W);

    localparam logic [IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
        logic cfg_hit;
    } t_sts;

endpackage

`default_nettype wire

[src/bavg_pix_if.sv]
`default_nettype none

interface bavg_pix_if
    import bavg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

`default_nettype wire

[src/bavg_res_if.sv]
`default_nettype none

interface bavg_res_if
    import bavg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] average;
    logic [OUT_W-1:0] out_col;
    logic [OUT_W-1:0] out_row;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output average, output out_col, output out_row,
                    output row_end, output frame_end, input ready);
    modport sink (input valid, input average, input out_col, input out_row,
                  input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

[src/bavg_ram.sv]
`default_nettype none

module bavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

[src/bavg_ctrl.sv]
`default_nettype none

module bavg_ctrl
    import bavg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_sts i_sts,
    output logic      o_ready,
    output t_cmd      o_cmd
);
    typedef enum logic [3:0] {
        S_READ = 4'b0001,
        S_IDLE = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        if (i_sts.cfg_hit) begin
            n_state = S_READ;
        end else begin
            case (r_state)
                S_READ: begin
                    n_state = S_IDLE;
                end
                S_IDLE: begin
                    o_ready = 1'b1;
                    if (i_valid) begin
                        o_cmd.accept = 1'b1;
                        if (i_sts.emit) begin
                            n_state = S_DIV;
                            n_cnt   = DIV_CNT_W'(SUM_W - 1);
                        end else begin
                            n_state = S_READ;
                        end
                    end
                end
                S_DIV: begin
                    o_cmd.div_step = 1'b1;
                    if (r_cnt == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_cnt = r_cnt - DIV_CNT_W'(1);
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_READ;
                    end
                end
                default: begin
                    n_state = S_READ;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_READ;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule

`default_nettype wire

[src/bavg_dpath.sv]
`default_nettype none

module bavg_dpath
    import bavg_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BLOCK = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic             i_out_ready,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic      [PIX_W-1:0] o_average,
    output logic      [OUT_W-1:0] o_out_col,
    output logic      [OUT_W-1:0] o_out_row,
    output logic                  o_row_end,
    output logic                  o_frame_end
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int BW  = $clog2(MAX_BLOCK + 1);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (WW0 > CFG_W) ? WW0 : CFG_W;
    localparam int PW  = WW + 2;
    localparam int EW  = (BW > BS_W) ? BW : BS_W;
    localparam int DW  = 2 * BW;

    logic [BS_W-1:0]  r_bs;
    logic [CFG_W-1:0] r_iw, r_ih;
    logic [XW-1:0]    r_x, r_x0, r_bx;
    logic [Y_W-1:0]   r_y, r_y0, r_by;
    logic [BW-1:0]    r_cib, r_rib;
    logic [SUM_W-1:0] r_rowp;

    logic [SUM_W-1:0] r_dvd;
    logic [DW-1:0]    r_rem, r_dsr;
    logic [OUT_W-1:0] r_pcol, r_prow;
    logic             r_pre, r_pfe;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_avg;
    logic [OUT_W-1:0] r_ocol, r_orow;
    logic             r_ore, r_ofe;

    logic [EW-1:0]    bs_ext;
    logic [BW-1:0]    b, b_m1;
    logic [WW-1:0]    iw_ext, w;
    logic [CFG_W-1:0] h;
    logic [PW-1:0]    b_p, b2_p, w_p, h_p, x_p, x0_p, y_p, y0_p;
    logic             in_x, in_y, act, col_last, row_first, row_last;
    logic             re, fe, x_wrap, y_wrap, mem_we, cfg_hit;
    logic [SUM_W-1:0] rp, ram_rdata, new_sum;
    logic [DW-1:0]    b_sq;
    logic [DW:0]      trial, dsr_ext, diff;
    logic             q_bit;
    logic [DW-1:0]    n_rem;

    // clamp the registers to their legal ranges
    always_comb begin
        bs_ext = EW'(r_bs);
        if (bs_ext == '0) begin
            b = BW'(1);
        end else if (bs_ext > EW'(MAX_BLOCK)) begin
            b = BW'(MAX_BLOCK);
        end else begin
            b = BW'(bs_ext);
        end
        iw_ext = WW'(r_iw);
        if (iw_ext == '0) begin
            w = WW'(1);
        end else if (iw_ext > WW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = iw_ext;
        end
        if (r_ih == '0) begin
            h = CFG_W'(1);
        end else if (r_ih > CFG_W'(HEIGHT_LIMIT)) begin
            h = CFG_W'(HEIGHT_LIMIT);
        end else begin
            h = r_ih;
        end
    end

    assign b_p  = PW'(b);
    assign b2_p = PW'(b) << 1;
    assign w_p  = PW'(w);
    assign h_p  = PW'(h);
    assign x_p  = PW'(r_x);
    assign x0_p = PW'(r_x0);
    assign y_p  = PW'(r_y);
    assign y0_p = PW'(r_y0);

    // the current block lies wholly inside the frame
    assign in_x = (x0_p + b_p) <= w_p;
    assign in_y = (y0_p + b_p) <= h_p;
    assign act  = in_x & in_y;
    assign re   = (x0_p + b2_p) > w_p;
    assign fe   = re & ((y0_p + b2_p) > h_p);

    assign b_m1      = b - BW'(1);
    assign col_last  = (r_cib == b_m1);
    assign row_first = (r_rib == '0);
    assign row_last  = (r_rib == b_m1);
    assign x_wrap    = (x_p + PW'(1)) >= w_p;
    assign y_wrap    = (y_p + PW'(1)) >= h_p;

    assign rp      = r_rowp + SUM_W'(i_pixel);
    assign new_sum = row_first ? rp : (ram_rdata + rp);
    assign mem_we  = i_cmd.accept & act & col_last & ~cfg_hit;
    assign b_sq    = DW'(b) * DW'(b);

    assign cfg_hit = i_cfg_we & ((i_cfg_idx == CFG_BLOCK_SIZE) ||
                                 (i_cfg_idx == CFG_IMAGE_WIDTH) ||
                                 (i_cfg_idx == CFG_IMAGE_HEIGHT));

    // one restoring division step
    assign trial   = {r_rem, r_dvd[SUM_W-1]};
    assign dsr_ext = {1'b0, r_dsr};
    assign diff    = trial - dsr_ext;
    assign q_bit   = trial >= dsr_ext;
    assign n_rem   = q_bit ? diff[DW-1:0] : trial[DW-1:0];

    bavg_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_bx),
        .i_wdata (new_sum),
        .i_raddr (r_bx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs        <= BS_W'(2);
            r_iw        <= CFG_W'(512);
            r_ih        <= CFG_W'(512);
            r_x         <= '0;
            r_x0        <= '0;
            r_bx        <= '0;
            r_y         <= '0;
            r_y0        <= '0;
            r_by        <= '0;
            r_cib       <= '0;
            r_rib       <= '0;
            r_rowp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_SIZE:   r_bs <= i_cfg_data[BS_W-1:0];
                    CFG_IMAGE_WIDTH:  r_iw <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_ih <= i_cfg_data;
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_x    <= '0;
                r_x0   <= '0;
                r_bx   <= '0;
                r_y    <= '0;
                r_y0   <= '0;
                r_by   <= '0;
                r_cib  <= '0;
                r_rib  <= '0;
                r_rowp <= '0;
            end else if (i_cmd.accept) begin
                if (x_wrap) begin
                    r_x    <= '0;
                    r_x0   <= '0;
                    r_bx   <= '0;
                    r_cib  <= '0;
                    r_rowp <= '0;
                    if (y_wrap) begin
                        r_y   <= '0;
                        r_y0  <= '0;
                        r_by  <= '0;
                        r_rib <= '0;
                    end else begin
                        r_y <= r_y + Y_W'(1);
                        if (row_last) begin
                            r_rib <= '0;
                            r_y0  <= r_y0 + Y_W'(b);
                            r_by  <= r_by + Y_W'(1);
                        end else begin
                            r_rib <= r_rib + BW'(1);
                        end
                    end
                end else begin
                    if (act) begin
                        r_rowp <= col_last ? '0 : rp;
                    end
                    r_x <= r_x + XW'(1);
                    if (col_last) begin
                        r_cib <= '0;
                        r_x0  <= r_x0 + XW'(b);
                        r_bx  <= r_bx + XW'(1);
                    end else begin
                        r_cib <= r_cib + BW'(1);
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_sts.emit) begin
            r_dvd  <= new_sum;
            r_rem  <= '0;
            r_dsr  <= b_sq;
            r_pcol <= OUT_W'(r_bx);
            r_prow <= OUT_W'(r_by);
            r_pre  <= re;
            r_pfe  <= fe;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[SUM_W-2:0], q_bit};
        end
        if (i_cmd.load_out) begin
            r_avg  <= r_dvd[PIX_W-1:0];
            r_ocol <= r_pcol;
            r_orow <= r_prow;
            r_ore  <= r_pre;
            r_ofe  <= r_pfe;
        end
    end

    assign o_sts.emit     = act & col_last & row_last;
    assign o_sts.out_free = ~r_out_valid | i_out_ready;
    assign o_sts.cfg_hit  = cfg_hit;

    assign o_out_valid = r_out_valid;
    assign o_average   = r_avg;
    assign o_out_col   = r_ocol;
    assign o_out_row   = r_orow;
    assign o_row_end   = r_ore;
    assign o_frame_end = r_ofe;
endmodule

`default_nettype wire

[src/block_average_downscale.sv]
// block average downscaler: 8-bit grayscale pixels enter in raster order on i_pix,
// one item per pixel; each whole block_size x block_size square gives one item on
// o_res with its truncated mean, reduced-image column and row, and row/frame end marks.
// pixels right of the last whole block column or below the last whole block row
// are taken and dropped. registers are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user writes them only while no item is in flight; the block does not enforce it.
// any valid write restarts the frame position. a pixel that completes no block takes
// a line store read, then its accept; one that completes a block then takes a
// 16-step restoring divider by block_size squared for the mean, and the result is
// loaded into the output register once that register is free.
// the output register parts the two sides: pixels keep flowing while a result
// waits; only the next finished result waits for o_res.ready.
// reset (synchronous, active low) restores block_size 2 and a 512 x 512 frame and
// clears all position state; the line store is not cleared, since the first row
// of each block overwrites its entry before it is read. i_pix.ready rises once the
// controller moves from S_READ to S_IDLE after reset is released.
`default_nettype none

module block_average_downscale
    import bavg_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BLOCK = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    bavg_pix_if.sink              i_pix,
    bavg_res_if.source            o_res,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    bavg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_sts   (sts),
        .o_ready (in_ready),
        .o_cmd   (cmd)
    );

    bavg_dpath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_pix.pixel),
        .i_out_ready (o_res.ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_res.valid),
        .o_average   (o_res.average),
        .o_out_col   (o_res.out_col),
        .o_out_row   (o_res.out_row),
        .o_row_end   (o_res.row_end),
        .o_frame_end (o_res.frame_end)
    );

    assign i_pix.ready = in_ready;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, cmd.accept, !in_ready, "ready held after accept")
    `ASSERT_NEXT(a_div_start, i_clk, i_rst_n, cmd.accept && sts.emit, cmd.div_step, "no div step")
    `ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, cmd.load_out, sts.out_free, "result overwritten")
endmodule

`default_nettype wire
